>>> hw/rtl/tbu_pkg.sv
// ----------------------------------------------------------------------------
// tbu_pkg
// Shared codes and types for the barycentric texture-coordinate block.
// ----------------------------------------------------------------------------
package tbu_pkg;

    // register indexes (paddr[5:3])
    localparam logic [2:0] REG_VERTEX_A = 3'd0;
    localparam logic [2:0] REG_VERTEX_B = 3'd1;
    localparam logic [2:0] REG_VERTEX_C = 3'd2;
    localparam logic [2:0] REG_TEX_A    = 3'd3;
    localparam logic [2:0] REG_TEX_B    = 3'd4;
    localparam logic [2:0] REG_TEX_C    = 3'd5;

    localparam int ADDR_W = 6;

    // projection plane codes
    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_XZ = 2'd1;
    localparam logic [1:0] PLANE_YZ = 2'd2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CNTW  = 4;

    typedef struct packed {
        logic empty;
        logic full;
        logic [FIFO_CNTW-1:0] count;
    } fifo_status_t;

endpackage

>>> hw/rtl/tbu_fifo.sv
// ----------------------------------------------------------------------------
// tbu_fifo
// Short queue between the setup front end and the blend/divide back end.
// ----------------------------------------------------------------------------
module tbu_fifo
    import tbu_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output fifo_status_t     status
);

    logic [WIDTH-1:0]     mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CNTW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FIFO_CNTW'(FIFO_DEPTH));
    assign status.count = count_reg;

endmodule

>>> hw/rtl/tbu_front.sv
// ----------------------------------------------------------------------------
// tbu_front
// Register file, projection-plane choice and determinant/weight numerators.
// ----------------------------------------------------------------------------
module tbu_front
    import tbu_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int TEX_FRAC_BITS = 16,
    localparam int CW1 = COORD_WIDTH + 1,
    localparam int PW  = 2 * CW1,
    localparam int DW  = PW + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    input  logic                          accept,
    input  logic signed [COORD_WIDTH-1:0] hit_x,
    input  logic signed [COORD_WIDTH-1:0] hit_y,
    input  logic signed [COORD_WIDTH-1:0] hit_z,
    output logic [2*TEX_FRAC_BITS-1:0]    tex_a_val,
    output logic [2*TEX_FRAC_BITS-1:0]    tex_b_val,
    output logic [2*TEX_FRAC_BITS-1:0]    tex_c_val,
    output logic                          out_valid,
    output logic signed [DW-1:0]          out_det,
    output logic signed [DW-1:0]          out_na,
    output logic signed [DW-1:0]          out_nb,
    output logic                          out_deg,
    output logic [2:0]                    inflight
);

    localparam int CW = COORD_WIDTH;
    localparam int VW = 3 * COORD_WIDTH;
    localparam int TW = 2 * TEX_FRAC_BITS;

    logic [VW-1:0] va_reg, vb_reg, vc_reg;
    logic [TW-1:0] ta_reg, tb_reg, tc_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
            ta_reg <= '0;
            tb_reg <= '0;
            tc_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_VERTEX_A: va_reg <= pwdata[VW-1:0];
                REG_VERTEX_B: vb_reg <= pwdata[VW-1:0];
                REG_VERTEX_C: vc_reg <= pwdata[VW-1:0];
                REG_TEX_A:    ta_reg <= pwdata[TW-1:0];
                REG_TEX_B:    tb_reg <= pwdata[TW-1:0];
                REG_TEX_C:    tc_reg <= pwdata[TW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VERTEX_A: prdata = 64'(va_reg);
            REG_VERTEX_B: prdata = 64'(vb_reg);
            REG_VERTEX_C: prdata = 64'(vc_reg);
            REG_TEX_A:    prdata = 64'(ta_reg);
            REG_TEX_B:    prdata = 64'(tb_reg);
            REG_TEX_C:    prdata = 64'(tc_reg);
            default:      prdata = '0;
        endcase
    end

    assign tex_a_val = ta_reg;
    assign tex_b_val = tb_reg;
    assign tex_c_val = tc_reg;

    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    assign ax = va_reg[0 +: CW];
    assign ay = va_reg[CW +: CW];
    assign az = va_reg[2*CW +: CW];
    assign bx = vb_reg[0 +: CW];
    assign by = vb_reg[CW +: CW];
    assign bz = vb_reg[2*CW +: CW];
    assign cx = vc_reg[0 +: CW];
    assign cy = vc_reg[CW +: CW];
    assign cz = vc_reg[2*CW +: CW];

    // stage 1: xy determinant products and equality flags
    logic signed [CW1-1:0] d_bycy, d_axcx, d_cxbx, d_aycy;
    logic signed [PW-1:0]  m_xy1, m_xy2;
    assign d_bycy = CW1'(by) - CW1'(cy);
    assign d_axcx = CW1'(ax) - CW1'(cx);
    assign d_cxbx = CW1'(cx) - CW1'(bx);
    assign d_aycy = CW1'(ay) - CW1'(cy);
    assign m_xy1  = d_bycy * d_axcx;
    assign m_xy2  = d_cxbx * d_aycy;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic signed [PW-1:0] s1_p1_reg, s1_p2_reg;
    logic                 s1_xeq_reg, s1_yeq_reg;
    logic signed [CW-1:0] s1_hx_reg, s1_hy_reg, s1_hz_reg;
    logic signed [CW-1:0] s2_hx_reg, s2_hy_reg, s2_hz_reg;
    logic [1:0]           s2_plane_reg;

    // stage 2: plane choice
    logic signed [DW-1:0] det_xy;
    logic [1:0]           plane_next;
    assign det_xy = DW'(s1_p1_reg) + DW'(s1_p2_reg);

    always_comb
    begin
        if (s1_xeq_reg)
        begin
            plane_next = PLANE_YZ;
        end
        else if (s1_yeq_reg || det_xy == '0)
        begin
            plane_next = PLANE_XZ;
        end
        else
        begin
            plane_next = PLANE_XY;
        end
    end

    // stage 3: pick s,t axes and form differences
    logic signed [CW-1:0] as_c, at_c, bs_c, bt_c, cs_c, ct_c, ps_c, pt_c;
    always_comb
    begin
        case (s2_plane_reg)
            PLANE_YZ:
            begin
                as_c = az; at_c = ay; bs_c = bz; bt_c = by;
                cs_c = cz; ct_c = cy; ps_c = s2_hz_reg; pt_c = s2_hy_reg;
            end
            PLANE_XZ:
            begin
                as_c = ax; at_c = az; bs_c = bx; bt_c = bz;
                cs_c = cx; ct_c = cz; ps_c = s2_hx_reg; pt_c = s2_hz_reg;
            end
            default:
            begin
                as_c = ax; at_c = ay; bs_c = bx; bt_c = by;
                cs_c = cx; ct_c = cy; ps_c = s2_hx_reg; pt_c = s2_hy_reg;
            end
        endcase
    end

    logic signed [CW1-1:0] s3_btct_reg, s3_ascs_reg, s3_csbs_reg, s3_atct_reg;
    logic signed [CW1-1:0] s3_ctat_reg, s3_pscs_reg, s3_ptct_reg;
    logic signed [PW-1:0]  s4_d1_reg, s4_d2_reg, s4_a1_reg, s4_a2_reg, s4_b1_reg, s4_b2_reg;
    logic signed [DW-1:0]  s5_det_reg, s5_na_reg, s5_nb_reg;
    logic                  s5_deg_reg;
    logic signed [DW-1:0]  det_sum;
    assign det_sum = DW'(s4_d1_reg) + DW'(s4_d2_reg);

    always_ff @(posedge clk)
    begin
        s1_p1_reg  <= m_xy1;
        s1_p2_reg  <= m_xy2;
        s1_xeq_reg <= (ax == bx) && (ax == cx);
        s1_yeq_reg <= (ay == by) && (ay == cy);
        s1_hx_reg  <= hit_x;
        s1_hy_reg  <= hit_y;
        s1_hz_reg  <= hit_z;

        s2_plane_reg <= plane_next;
        s2_hx_reg    <= s1_hx_reg;
        s2_hy_reg    <= s1_hy_reg;
        s2_hz_reg    <= s1_hz_reg;

        s3_btct_reg <= CW1'(bt_c) - CW1'(ct_c);
        s3_ascs_reg <= CW1'(as_c) - CW1'(cs_c);
        s3_csbs_reg <= CW1'(cs_c) - CW1'(bs_c);
        s3_atct_reg <= CW1'(at_c) - CW1'(ct_c);
        s3_ctat_reg <= CW1'(ct_c) - CW1'(at_c);
        s3_pscs_reg <= CW1'(ps_c) - CW1'(cs_c);
        s3_ptct_reg <= CW1'(pt_c) - CW1'(ct_c);

        s4_d1_reg <= s3_btct_reg * s3_ascs_reg;
        s4_d2_reg <= s3_csbs_reg * s3_atct_reg;
        s4_a1_reg <= s3_btct_reg * s3_pscs_reg;
        s4_a2_reg <= s3_csbs_reg * s3_ptct_reg;
        s4_b1_reg <= s3_ctat_reg * s3_pscs_reg;
        s4_b2_reg <= s3_ascs_reg * s3_ptct_reg;

        s5_det_reg <= det_sum;
        s5_na_reg  <= DW'(s4_a1_reg) + DW'(s4_a2_reg);
        s5_nb_reg  <= DW'(s4_b1_reg) + DW'(s4_b2_reg);
        s5_deg_reg <= (det_sum == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_det   = s5_det_reg;
    assign out_na    = s5_na_reg;
    assign out_nb    = s5_nb_reg;
    assign out_deg   = s5_deg_reg;
    assign inflight  = 3'($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                                       s4_valid_reg, s5_valid_reg}));

endmodule

>>> hw/rtl/tbu_div.sv
// ----------------------------------------------------------------------------
// tbu_div
// Pipelined restoring divider, one quotient bit per stage; keeps low bits.
// ----------------------------------------------------------------------------
module tbu_div
#(
    parameter int NW = 54,
    parameter int DW = 35,
    parameter int QW = 16
)
(
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [QW-1:0] quo_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] num_src;
        logic [DW-1:0] rem_src;
        logic [DW-1:0] den_src;
        logic [QW-1:0] quo_src;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign num_src = num;
            assign rem_src = '0;
            assign den_src = den;
            assign quo_src = '0;
        end
        else
        begin : g_next
            assign num_src = num_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign quo_src = quo_reg[k-1];
        end

        assign trial = {rem_src, num_src[NW-1]};
        assign ge    = (trial >= {1'b0, den_src});

        always_ff @(posedge clk)
        begin
            num_reg[k] <= num_src << 1;
            rem_reg[k] <= ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
            den_reg[k] <= den_src;
            quo_reg[k] <= {quo_src[QW-2:0], ge};
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

>>> hw/rtl/tbu_back.sv
// ----------------------------------------------------------------------------
// tbu_back
// Texture blend numerators, sign split, two divider lanes, fraction output.
// ----------------------------------------------------------------------------
module tbu_back
#(
    parameter int COORD_WIDTH   = 16,
    parameter int TEX_FRAC_BITS = 16,
    localparam int DW = 2 * (COORD_WIDTH + 1) + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [DW-1:0]          in_det,
    input  logic signed [DW-1:0]          in_na,
    input  logic signed [DW-1:0]          in_nb,
    input  logic                          in_deg,
    input  logic [2*TEX_FRAC_BITS-1:0]    tex_a_val,
    input  logic [2*TEX_FRAC_BITS-1:0]    tex_b_val,
    input  logic [2*TEX_FRAC_BITS-1:0]    tex_c_val,
    output logic                          done,
    output logic signed [TEX_FRAC_BITS:0] tex_u,
    output logic signed [TEX_FRAC_BITS:0] tex_v,
    output logic                          degenerate
);

    localparam int TF  = TEX_FRAC_BITS;
    localparam int PRW = DW + TF + 1;
    localparam int NW  = PRW + 2;

    logic signed [TF:0] ua, ub, uc, va, vb, vc;
    assign ua = $signed({1'b0, tex_a_val[TF-1:0]});
    assign ub = $signed({1'b0, tex_b_val[TF-1:0]});
    assign uc = $signed({1'b0, tex_c_val[TF-1:0]});
    assign va = $signed({1'b0, tex_a_val[2*TF-1:TF]});
    assign vb = $signed({1'b0, tex_b_val[2*TF-1:TF]});
    assign vc = $signed({1'b0, tex_c_val[2*TF-1:TF]});

    // B1: products
    logic signed [PRW-1:0] b1_pu0_reg, b1_pu1_reg, b1_pu2_reg;
    logic signed [PRW-1:0] b1_pv0_reg, b1_pv1_reg, b1_pv2_reg;
    logic signed [DW-1:0]  b1_det_reg;
    logic                  b1_deg_reg, b1_valid_reg;

    always_ff @(posedge clk)
    begin
        b1_pu0_reg <= uc * in_det;
        b1_pu1_reg <= in_na * (ua - uc);
        b1_pu2_reg <= in_nb * (ub - uc);
        b1_pv0_reg <= vc * in_det;
        b1_pv1_reg <= in_na * (va - vc);
        b1_pv2_reg <= in_nb * (vb - vc);
        b1_det_reg <= in_det;
        b1_deg_reg <= in_deg;
    end

    // B2: exact numerators, split into sign and magnitude
    logic signed [NW-1:0] nu, nv;
    logic                 det_neg;
    assign nu      = NW'(b1_pu0_reg) + NW'(b1_pu1_reg) + NW'(b1_pu2_reg);
    assign nv      = NW'(b1_pv0_reg) + NW'(b1_pv1_reg) + NW'(b1_pv2_reg);
    assign det_neg = b1_det_reg[DW-1];

    logic [NW-1:0] b2_nu_reg, b2_nv_reg;
    logic [DW-1:0] b2_den_reg;
    logic          b2_negu_reg, b2_negv_reg, b2_deg_reg, b2_valid_reg;

    always_ff @(posedge clk)
    begin
        b2_nu_reg   <= nu[NW-1] ? NW'(-nu) : NW'(nu);
        b2_nv_reg   <= nv[NW-1] ? NW'(-nv) : NW'(nv);
        b2_den_reg  <= det_neg ? DW'(-b1_det_reg) : DW'(b1_det_reg);
        b2_negu_reg <= nu[NW-1] ^ det_neg;
        b2_negv_reg <= nv[NW-1] ^ det_neg;
        b2_deg_reg  <= b1_deg_reg;
    end

    logic [TF-1:0] qu, qv;

    tbu_div #(.NW(NW), .DW(DW), .QW(TF)) u_div_u
    (
        .clk (clk),
        .num (b2_nu_reg),
        .den (b2_den_reg),
        .quo (qu)
    );

    tbu_div #(.NW(NW), .DW(DW), .QW(TF)) u_div_v
    (
        .clk (clk),
        .num (b2_nv_reg),
        .den (b2_den_reg),
        .quo (qv)
    );

    // sideband follows the divider stages
    logic [NW-1:0] pipe_valid_reg, pipe_deg_reg, pipe_negu_reg, pipe_negv_reg;

    always_ff @(posedge clk)
    begin
        pipe_deg_reg  <= {pipe_deg_reg[NW-2:0], b2_deg_reg};
        pipe_negu_reg <= {pipe_negu_reg[NW-2:0], b2_negu_reg};
        pipe_negv_reg <= {pipe_negv_reg[NW-2:0], b2_negv_reg};
    end

    logic signed [TF:0] frac_u, frac_v;
    assign frac_u = pipe_negu_reg[NW-1] ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
    assign frac_v = pipe_negv_reg[NW-1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});

    logic               done_reg, deg_out_reg;
    logic signed [TF:0] tex_u_reg, tex_v_reg;

    always_ff @(posedge clk)
    begin
        tex_u_reg   <= pipe_deg_reg[NW-1] ? '0 : frac_u;
        tex_v_reg   <= pipe_deg_reg[NW-1] ? '0 : frac_v;
        deg_out_reg <= pipe_deg_reg[NW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            pipe_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            b1_valid_reg   <= in_valid;
            b2_valid_reg   <= b1_valid_reg;
            pipe_valid_reg <= {pipe_valid_reg[NW-2:0], b2_valid_reg};
            done_reg       <= pipe_valid_reg[NW-1];
        end
    end

    assign done       = done_reg;
    assign tex_u      = tex_u_reg;
    assign tex_v      = tex_v_reg;
    assign degenerate = deg_out_reg & done_reg;

endmodule

>>> hw/rtl/triangle_barycentric_uv.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_uv
// Barycentric texture-coordinate interpolation of hit points on one triangle.
//
//   channel  signals                              beat taken when
//   cfg      psel penable pwrite paddr pwdata     psel & penable & pwrite
//   in       start hit_x hit_y hit_z              start & !busy
//   out      done tex_u tex_v degenerate          done (one cycle)
//
// One beat per cycle sustained while busy is low. The dividers work one bit per
// stage over an NW-bit numerator, NW = 2*COORD_WIDTH + TEX_FRAC_BITS + 6.
// rst_n clears control state and the registers asynchronously.
// busy rises only if the setup stages plus queue could overflow; the back
// end drains one beat every cycle, so it does not rise in normal use.
// ----------------------------------------------------------------------------
module triangle_barycentric_uv
    import tbu_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int TEX_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] hit_x,
    input  logic signed [COORD_WIDTH-1:0] hit_y,
    input  logic signed [COORD_WIDTH-1:0] hit_z,
    output logic                          done,
    output logic signed [TEX_FRAC_BITS:0] tex_u,
    output logic signed [TEX_FRAC_BITS:0] tex_v,
    output logic                          degenerate
);

    localparam int DW = 2 * (COORD_WIDTH + 1) + 1;
    localparam int QW = 3 * DW + 1;
    localparam int TW = 2 * TEX_FRAC_BITS;

    logic                 accept;
    logic [TW-1:0]        tex_a_val, tex_b_val, tex_c_val;
    logic                 fr_valid, fr_deg;
    logic signed [DW-1:0] fr_det, fr_na, fr_nb;
    logic [2:0]           inflight;
    logic [QW-1:0]        q_rd;
    fifo_status_t         q_status;
    logic                 q_pop;
    logic [FIFO_CNTW:0]   pending;

    assign pready  = 1'b1;
    assign pending = (FIFO_CNTW+1)'(inflight) + (FIFO_CNTW+1)'(q_status.count);
    assign busy    = (pending >= (FIFO_CNTW+1)'(FIFO_DEPTH));
    assign accept  = start && !busy;
    assign q_pop   = !q_status.empty;

    tbu_front #(.COORD_WIDTH(COORD_WIDTH), .TEX_FRAC_BITS(TEX_FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .accept    (accept),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .tex_a_val (tex_a_val),
        .tex_b_val (tex_b_val),
        .tex_c_val (tex_c_val),
        .out_valid (fr_valid),
        .out_det   (fr_det),
        .out_na    (fr_na),
        .out_nb    (fr_nb),
        .out_deg   (fr_deg),
        .inflight  (inflight)
    );

    tbu_fifo #(.WIDTH(QW)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_valid),
        .wr_data ({fr_deg, fr_det, fr_na, fr_nb}),
        .pop     (q_pop),
        .rd_data (q_rd),
        .status  (q_status)
    );

    tbu_back #(.COORD_WIDTH(COORD_WIDTH), .TEX_FRAC_BITS(TEX_FRAC_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_pop),
        .in_det     (q_rd[2*DW +: DW]),
        .in_na      (q_rd[DW +: DW]),
        .in_nb      (q_rd[0 +: DW]),
        .in_deg     (q_rd[QW-1]),
        .tex_a_val  (tex_a_val),
        .tex_b_val  (tex_b_val),
        .tex_c_val  (tex_c_val),
        .done       (done),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .degenerate (degenerate)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid |-> !q_status.full)
        else $error("queue overflow");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (tex_u == '0 && tex_v == '0))
        else $error("degenerate result not zero");

    a_deg_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        degenerate |-> done)
        else $error("degenerate without done");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= FIFO_CNTW'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule
